[sv/apdf_pkg.sv]
// ============================================================================
// apdf_pkg
// Shared constants and types for the allpass delay filter.
// ============================================================================
`default_nettype none

package apdf_pkg;

  // Fixed register widths of the configuration port.
  localparam int DLEN_W    = 13;
  localparam int GAIN_W    = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 1;

  // The gain is unsigned Q0.15, so products are scaled by 2^15.
  localparam int GAIN_FRAC = 15;

  // Largest allowed gain, 0.99 in Q0.15.
  localparam logic [GAIN_W-1:0] GAIN_MAX = 15'd32440;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH  = 1'b0,
    REG_FEEDBACK_GAIN = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

[sv/allpass_delay_filter.sv]
// ============================================================================
// allpass_delay_filter
// Allpass section over a circular delay store: out = d - g*x, and x + g*d is
// written back, where d is the value stored delay_length samples earlier.
// ============================================================================
//
//   Channel   Signals                          Direction  Moves
//   -------   -------------------------------  ---------  ---------------------
//   in        in_valid, in_ready, in_sample    to block   one request per sample
//   out       out_valid, out_ready, out_sample from block one request per sample
//   cfg       cfg_write, cfg_index, cfg_data   to block   register write
//
// One sample is accepted every cycle unless the output stalls. The delay
// store read and the read stage load when a request is taken, and the result
// register loads when the read stage moves on. The delay store has a single
// read and a single write port. Reset needs no clearing pass: a fill mark
// makes entries never written read as zero. A stalled output holds one
// result while one more request is taken into the read stage.
// ============================================================================
`default_nettype none

module allpass_delay_filter
  import apdf_pkg::*;
#(
  parameter int MAX_DELAY   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      signed [SAMPLE_BITS-1:0] out_sample,
  input  wire logic                          cfg_write,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic        [CFG_W-1:0]       cfg_data
);

  localparam int AW   = $clog2(MAX_DELAY);
  localparam int LENW = AW + 1;
  localparam logic [LENW-1:0] MAX_LEN = LENW'(MAX_DELAY);
  localparam logic [AW-1:0]   LAST_POS = AW'(MAX_DELAY - 1);

  // Configuration registers, kept already clamped to their legal ranges.
  logic [LENW-1:0]   delay_len;
  logic [GAIN_W-1:0] gain;

  // Write position of the next request and the fill mark. Until the
  // position has wrapped once, only entries below it have been written.
  logic [AW-1:0] wr_pos;
  logic          wrapped;

  // Read stage: the request whose delay tap is being read from the store.
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic [AW-1:0]                 s1_pos;
  logic                          s1_written;
  logic                          s1_byp;
  logic signed [SAMPLE_BITS-1:0] s1_byp_data;

  logic                          s1_fire;
  logic                          accept;
  logic [LENW-1:0]               pos_ext;
  logic [LENW-1:0]               rd_ext;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_written;
  logic                          rd_byp;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] tap;
  logic signed [SAMPLE_BITS-1:0] y_val;
  logic signed [SAMPLE_BITS-1:0] w_val;
  logic [DLEN_W-1:0]             len_in;

  // The read stage moves on whenever the result register is free or is
  // being emptied this cycle; a new request may enter as it moves on.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign accept   = in_valid && in_ready;

  // Tap address: write position minus the delay, modulo the store depth.
  assign pos_ext = {1'b0, wr_pos};
  always_comb begin
    if (pos_ext >= delay_len) begin
      rd_ext = pos_ext - delay_len;
    end else begin
      rd_ext = pos_ext + MAX_LEN - delay_len;
    end
  end
  assign rd_addr = rd_ext[AW-1:0];

  // An entry is valid once written; a delay equal to the depth reads the
  // entry about to be overwritten, which is handled by the same test.
  assign rd_written = wrapped || (rd_addr < wr_pos);

  // With a delay of one sample the tap is the entry that the request in
  // the read stage writes at this very edge, so its value is forwarded.
  assign rd_byp = s1_valid && (s1_pos == rd_addr);

  apdf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_DELAY)
  ) u_store (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_pos),
    .wdata (w_val),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (s1_byp) begin
      tap = s1_byp_data;
    end else if (s1_written) begin
      tap = $signed(ram_rdata);
    end else begin
      tap = '0;
    end
  end

  apdf_arith #(
    .SW (SAMPLE_BITS)
  ) u_arith (
    .x    (s1_x),
    .d    (tap),
    .gain (gain),
    .y    (y_val),
    .w    (w_val)
  );

  // Configuration writes. A zero delay counts as one, and a delay longer
  // than the store counts as the full depth; the gain is capped at 0.99.
  assign len_in = cfg_data[DLEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_len <= LENW'(1);
      gain      <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_DELAY_LENGTH: begin
          if (len_in == '0) begin
            delay_len <= LENW'(1);
          end else if (int'(len_in) > MAX_DELAY) begin
            delay_len <= MAX_LEN;
          end else begin
            delay_len <= LENW'(len_in);
          end
        end
        REG_FEEDBACK_GAIN: begin
          if (cfg_data[GAIN_W-1:0] > GAIN_MAX) begin
            gain <= GAIN_MAX;
          end else begin
            gain <= cfg_data[GAIN_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Write position and fill mark advance with each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos  <= '0;
      wrapped <= 1'b0;
    end else if (accept) begin
      if (wr_pos == LAST_POS) begin
        wr_pos  <= '0;
        wrapped <= 1'b1;
      end else begin
        wr_pos <= wr_pos + AW'(1);
      end
    end
  end

  // Read stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x        <= in_sample;
      s1_pos      <= wr_pos;
      s1_written  <= rd_written;
      s1_byp      <= rd_byp;
      s1_byp_data <= w_val;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_sample <= y_val;
    end
  end

endmodule

`default_nettype wire

[sv/apdf_ram.sv]
// ============================================================================
// apdf_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read. A read of the address being written returns old data.
// ============================================================================
`default_nettype none

module apdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[sv/apdf_arith.sv]
// ============================================================================
// apdf_arith
// Allpass datapath: y = d - g*x and w = x + g*d, each rounded half up from
// the 2^15 scale and saturated to the sample width.
// ============================================================================
`default_nettype none

module apdf_arith
  import apdf_pkg::*;
#(
  parameter int SW = 16
) (
  input  wire logic signed [SW-1:0]     x,
  input  wire logic signed [SW-1:0]     d,
  input  wire logic        [GAIN_W-1:0] gain,
  output logic      signed [SW-1:0]     y,
  output logic      signed [SW-1:0]     w
);

  localparam int MW = SW + GAIN_W + 1;
  localparam int PW = SW + GAIN_FRAC + 2;

  localparam logic signed [PW-1:0] RND  = PW'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [PW-1:0] SMAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = {{(PW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  function automatic logic signed [SW-1:0] round_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    logic signed [PW-1:0] q;
    r = v + RND;
    q = r >>> GAIN_FRAC;
    if (q > SMAX) begin
      q = SMAX;
    end else if (q < SMIN) begin
      q = SMIN;
    end
    return q[SW-1:0];
  endfunction

  logic signed [GAIN_W:0] g_s;
  logic signed [MW-1:0]   gx;
  logic signed [MW-1:0]   gd;
  logic signed [PW-1:0]   sum_y;
  logic signed [PW-1:0]   sum_w;

  assign g_s = {1'b0, gain};
  assign gx  = g_s * x;
  assign gd  = g_s * d;

  assign sum_y = (PW'(d) <<< GAIN_FRAC) - PW'(gx);
  assign sum_w = (PW'(x) <<< GAIN_FRAC) + PW'(gd);

  assign y = round_sat(sum_y);
  assign w = round_sat(sum_w);

endmodule

`default_nettype wire

[test/testbench.sv]
// ============================================================================
// testbench
// Self-checking bench for the allpass delay filter. A behavioral copy of the
// allpass section, with its own delay store and write pointer, predicts each
// output sample as its request is taken. A monitor compares every result in
// order against those predictions while both channels stall at random.
// ============================================================================
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import apdf_pkg::*;

  localparam int STORE_DEPTH  = 4096;
  localparam int SAMPLE_W     = 16;
  localparam int SAMPLE_MAX   = 32767;
  localparam int SAMPLE_MIN   = -32768;
  // Cycles without any request moving before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Idle cycles after the last owed result, to show any stray result.
  localparam int DRAIN_CYCLES = 5;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample  = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index  = REG_DELAY_LENGTH;
  logic [CFG_W-1:0]           cfg_data   = '0;

  // Shadow copy of the filter: registers, delay store and write pointer.
  logic [DLEN_W-1:0]          tap_length;
  logic [GAIN_W-1:0]          gain_q15;
  logic signed [SAMPLE_W-1:0] echo_store [STORE_DEPTH];
  logic [11:0]                write_ptr;

  // Output samples still owed by the block, oldest first.
  logic signed [SAMPLE_W-1:0] expected_out [$];
  logic signed [SAMPLE_W-1:0] want_sample;
  int                         errors       = 0;
  int                         stall_cycles = 0;
  // When set, neither side idles: requests go out and results are taken
  // on every cycle.
  bit                         full_rate    = 1'b0;

  allpass_delay_filter #(
    .MAX_DELAY  (STORE_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sample(out_sample),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5ns clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Brings a sum scaled by 2^15 back to sample scale, rounding half up (the
  // arithmetic shift floors), and then clips it to the signed sample range.
  function automatic logic signed [SAMPLE_W-1:0] round_sat(input longint acc);
    longint q;
    q = (acc + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (q > SAMPLE_MAX) begin
      q = SAMPLE_MAX;
    end else if (q < SAMPLE_MIN) begin
      q = SAMPLE_MIN;
    end
    return SAMPLE_W'(q);
  endfunction

  // Runs one sample through the shadow filter. The tap d is read before the
  // write, so at the full store length it is the entry about to be replaced.
  // The output is d - g*x and x + g*d goes back into the store.
  function automatic logic signed [SAMPLE_W-1:0] allpass_step(
    input logic signed [SAMPLE_W-1:0] x
  );
    int                         len;
    longint                     g;
    longint                     d;
    longint                     xs;
    logic [11:0]                rd;
    logic signed [SAMPLE_W-1:0] y;
    // A length of zero acts as one, and anything past the store depth
    // acts as the full depth.
    len = tap_length;
    if (len < 1) begin
      len = 1;
    end else if (len > STORE_DEPTH) begin
      len = STORE_DEPTH;
    end
    // Gains above 0.99 are clamped.
    g  = (gain_q15 > GAIN_MAX) ? GAIN_MAX : gain_q15;
    rd = write_ptr - 12'(len);
    d  = echo_store[rd];
    xs = x;
    y  = round_sat((d <<< GAIN_FRAC) - g * xs);
    echo_store[write_ptr] = round_sat((xs <<< GAIN_FRAC) + g * d);
    write_ptr = write_ptr + 1'b1;
    return y;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers and result monitor
  // ---------------------------------------------------------------------------

  // The receiver holds back in roughly a third of the cycles unless the
  // bench is running at full rate.
  always @(posedge clk) begin
    out_ready <= full_rate || ($urandom_range(99) >= 35);
  end

  // Every result taken is checked against the oldest prediction. A
  // mismatch is logged and counted, and the run carries on.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        $display("%0t: result with no request pending: expected none, got %0d",
                 $time, out_sample);
        errors++;
      end else begin
        want_sample = expected_out.pop_front();
        if (out_sample !== want_sample) begin
          $display("%0t: out_sample mismatch: expected %0d, got %0d",
                   $time, want_sample, out_sample);
          errors++;
        end
      end
    end
  end

  // Watchdog: if no request moves on either channel for too long, the block
  // is taken to be hung and the run ends.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offers one sample, possibly after a short random gap, and waits until the
  // request is taken. The prediction is made at that same edge. Valid is left
  // high so that a following request goes out back to back; it is lowered only
  // by a gap, a register write, or the end of the stimulus.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x);
    if (!full_rate && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (!in_ready);
    expected_out.push_back(allpass_step(x));
  endtask

  // Lets the block drain and then writes both registers in consecutive
  // cycles. Writes are only issued with no request in flight.
  task automatic program_filter(input logic [CFG_W-1:0] length_word,
                                input logic [CFG_W-1:0] gain_word);
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_DELAY_LENGTH;
    cfg_data  <= length_word;
    @(posedge clk);
    cfg_index <= REG_FEEDBACK_GAIN;
    cfg_data  <= gain_word;
    @(posedge clk);
    cfg_write <= 1'b0;
    // Only the low bits of the length word land in its register.
    tap_length = length_word[DLEN_W-1:0];
    gain_q15   = gain_word[GAIN_W-1:0];
  endtask

  // Random sample: mostly anywhere in range, sometimes at full scale,
  // sometimes small so that the feedback path builds up without clipping.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_W'(SAMPLE_MAX);
      1:       return SAMPLE_W'(SAMPLE_MIN);
      2, 3:    return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the tap is one sample long and the gain is zero, so the
  // block is a plain one-sample delay starting from a cleared store.
  task automatic test_reset_defaults();
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample('0);
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(-1));
  endtask

  // Full-scale samples of both signs at the largest gain drive both sums
  // into saturation. A gain word above the limit must act as the limit.
  task automatic test_gain_limits();
    program_filter(15'd1, GAIN_MAX);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample('0);
    program_filter(15'd1, 15'h7FFF);
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    send_sample(SAMPLE_W'(SAMPLE_MAX));
  endtask

  // A delay length of zero must behave as a length of one.
  task automatic test_zero_delay();
    program_filter(15'd0, 15'd16384);
    send_sample(SAMPLE_W'(1000));
    send_sample(SAMPLE_W'(-1000));
    send_sample(SAMPLE_W'(12345));
  endtask

  // Lengths past the store depth clamp to the full depth. The first write
  // sets every data bit, including the ones the length register drops.
  task automatic test_long_delay_clamp();
    program_filter(15'h7FFF, 15'h7FFF);
    send_sample(SAMPLE_W'(SAMPLE_MAX));
    send_sample(SAMPLE_W'(-20000));
    send_sample(SAMPLE_W'(SAMPLE_MIN));
    program_filter(15'(STORE_DEPTH + 1), 15'd0);
    send_sample(SAMPLE_W'(777));
    send_sample(SAMPLE_W'(-777));
  endtask

  // Random phases, each with fresh settings. The store is never cleared, so
  // every new tap picks up whatever earlier phases left behind. Short taps
  // dominate so that the feedback loop goes round many times per phase.
  task automatic test_random_stream();
    logic [CFG_W-1:0] length_word;
    logic [CFG_W-1:0] gain_word;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(9))
        0:       length_word = CFG_W'($urandom);
        1:       length_word = CFG_W'(STORE_DEPTH);
        2, 3:    length_word = CFG_W'($urandom_range(65, 1500));
        default: length_word = CFG_W'($urandom_range(1, 64));
      endcase
      case ($urandom_range(5))
        0:       gain_word = '0;
        1:       gain_word = GAIN_MAX;
        2:       gain_word = CFG_W'($urandom_range(GAIN_MAX + 1, 32767));
        default: gain_word = CFG_W'($urandom_range(0, GAIN_MAX));
      endcase
      program_filter(length_word, gain_word);
      // One phase runs with no idling on either side.
      full_rate = (phase == 4);
      repeat (60) send_sample(pick_sample());
    end
    full_rate = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    // The shadow filter starts from the reset state of the block.
    for (int i = 0; i < STORE_DEPTH; i++) begin
      echo_store[i] = '0;
    end
    write_ptr  = '0;
    tap_length = DLEN_W'(1);
    gain_q15   = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_gain_limits();
    test_zero_delay();
    test_long_delay_clamp();
    test_random_stream();

    // Stop offering requests, collect the results still owed, and then idle
    // for DRAIN_CYCLES so that any stray result shows.
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/apdf_pkg.sv
sv/apdf_ram.sv
sv/apdf_arith.sv
sv/allpass_delay_filter.sv
test/testbench.sv
